// ----- hdl/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg
// shared widths, codes, state types and helpers of the spring force block
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int VTX_W   = 10;
    localparam int POS_W   = 32;
    localparam int FRC_W   = 48;
    localparam int DIFF_W  = POS_W + 1;
    localparam int ROOT_W  = 34;
    localparam int SUM_W   = 2 * ROOT_W;
    localparam int SQR_W   = ROOT_W + 2;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int KE_W    = 66;
    localparam int KE_HALF = KE_W / 2;
    localparam int NUM_W   = 99;
    localparam int FRAC_W  = 16;
    localparam int DVS_W   = ROOT_W + FRAC_W;
    localparam int CNT_W   = 7;
    localparam int ESUB_W  = ROOT_W + 1;
    localparam int ACC_W   = 3 * FRC_W;

    localparam logic OP_SPRING   = 1'b0;
    localparam logic OP_READ     = 1'b1;
    localparam logic KIND_FORCE  = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    localparam logic signed [FRC_W-1:0] FRC_MAX = {1'b0, {(FRC_W-1){1'b1}}};
    localparam logic signed [FRC_W-1:0] FRC_MIN = {1'b1, {(FRC_W-1){1'b0}}};

    typedef enum logic [3:0] {
        F_IDLE,
        F_SQ,
        F_SQRT,
        F_KE,
        F_MLO,
        F_MHI,
        F_DIV,
        F_SAT,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RD0,
        B_WR0,
        B_RD1,
        B_WR1,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic                     opcode;
        logic [VTX_W-1:0]         first_vertex;
        logic [VTX_W-1:0]         second_vertex;
        logic signed [FRC_W-1:0]  force_x;
        logic signed [FRC_W-1:0]  force_y;
        logic signed [FRC_W-1:0]  force_z;
        logic                     degenerate;
    } work_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } back_status_t;

    function automatic logic signed [FRC_W-1:0] sat_sum(
        input logic signed [FRC_W-1:0] a,
        input logic signed [FRC_W-1:0] b,
        input logic                    sub
    );
        logic signed [FRC_W:0] s;
        s = sub ? ({a[FRC_W-1], a} - {b[FRC_W-1], b}) : ({a[FRC_W-1], a} + {b[FRC_W-1], b});
        if (s[FRC_W] != s[FRC_W-1])
        begin
            return s[FRC_W] ? FRC_MIN : FRC_MAX;
        end
        return s[FRC_W-1:0];
    endfunction

    function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] d);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

// ----- hdl/sfa_if.sv -----
// ----------------------------------------------------------------------------
// sfa_if
// valid/ready channels for spring items and force results
// ----------------------------------------------------------------------------
interface sfa_in_if;
    import sfa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [VTX_W-1:0]        first_vertex;
    logic [VTX_W-1:0]        second_vertex;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
    logic [POS_W-1:0]        stiffness;
    logic [POS_W-1:0]        rest_length;

    modport source (
        output valid, opcode, first_vertex, second_vertex,
        output first_x, first_y, first_z, second_x, second_y, second_z,
        output stiffness, rest_length,
        input  ready
    );

    modport sink (
        input  valid, opcode, first_vertex, second_vertex,
        input  first_x, first_y, first_z, second_x, second_y, second_z,
        input  stiffness, rest_length,
        output ready
    );
endinterface

interface sfa_out_if;
    import sfa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [VTX_W-1:0]        vertex;
    logic signed [FRC_W-1:0] force_x;
    logic signed [FRC_W-1:0] force_y;
    logic signed [FRC_W-1:0] force_z;
    logic                    degenerate;

    modport source (
        output valid, kind, vertex, force_x, force_y, force_z, degenerate,
        input  ready
    );

    modport sink (
        input  valid, kind, vertex, force_x, force_y, force_z, degenerate,
        output ready
    );
endinterface

// ----- hdl/spring_force_accumulator.sv -----
// ----------------------------------------------------------------------------
// spring_force_accumulator
// hooke spring force per item, accumulated per vertex, with read and clear
//
//   channel   role    carries
//   in_ch     sink    opcode, vertex indices, endpoints, stiffness, rest length
//   out_ch    source  kind, vertex, force x/y/z, degenerate
//
// front steps of a spring: accept, 3 squares, 34 square root steps, the
// stiffness times extension product, then per component two partial
// products, 99 divider steps and a saturation step, then the queue push
// readouts go straight to the push; the back ends one item before the next
// after reset all NUM_VERTICES accumulator entries are cleared, with
// in_ch.ready low; a stalled output holds in its register while the queue
// lets the front keep working on the next transaction
// ----------------------------------------------------------------------------
module spring_force_accumulator #(
    parameter int NUM_VERTICES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    sfa_in_if.sink     in_ch,
    sfa_out_if.source  out_ch
);
    import sfa_pkg::*;

    back_status_t status;
    work_t        q_in, q_head;
    logic         q_push, q_full, q_pop, q_empty;

    sfa_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .status (status),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    sfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    sfa_back #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .empty  (q_empty),
        .pop    (q_pop),
        .status (status),
        .out_ch (out_ch)
    );
endmodule

// ----- hdl/sfa_ram.sv -----
// ----------------------------------------------------------------------------
// sfa_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module sfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/sfa_front.sv -----
// ----------------------------------------------------------------------------
// sfa_front
// accepts items and works out the spring force with a shared multiplier,
// a bit-serial square root and a bit-serial divider
// ----------------------------------------------------------------------------
module sfa_front (
    input  logic                 clk,
    input  logic                 rst_n,
    sfa_in_if.sink               in_ch,
    input  sfa_pkg::back_status_t status,
    input  logic                 q_full,
    output logic                 q_push,
    output sfa_pkg::work_t       q_data
);
    import sfa_pkg::*;

    front_state_t state_reg, state_next;
    logic [1:0]       j_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic                     op_reg;
    logic [VTX_W-1:0]         v0_reg, v1_reg;
    logic signed [DIFF_W-1:0] d_reg [3];
    logic [POS_W-1:0]         k_reg, l_reg;
    logic [SUM_W-1:0]         acc_reg;
    logic [SQR_W-1:0]         sq_rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [KE_W-1:0]          ke_reg;
    logic                     e_neg_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DVS_W-1:0]         div_rem_reg;
    logic signed [FRC_W-1:0]  f_reg [3];
    logic                     degen_reg;

    logic                     accept;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]        prod;
    logic [DIFF_W-1:0]        dmag;
    logic [SQR_W+1:0]         sq_sh, sq_trial;
    logic [SQR_W-1:0]         sq_rem_next;
    logic [ROOT_W-1:0]        root_next;
    logic signed [ESUB_W-1:0] e_val;
    logic [ROOT_W-1:0]        e_mag;
    logic [DVS_W:0]           dv_sh, dv_dvs;
    logic                     dv_bit;
    logic [DVS_W-1:0]         dv_rem_next;
    logic                     neg, big_pos, big_neg;
    logic signed [FRC_W-1:0]  f_sat;

    assign accept = in_ch.valid && in_ch.ready;
    assign dmag   = mag_diff(d_reg[j_reg]);

    // square root digit step
    assign sq_sh       = {sq_rem_reg, acc_reg[SUM_W-1 -: 2]};
    assign sq_trial    = {2'b00, root_reg, 2'b01};
    assign sq_rem_next = (sq_sh >= sq_trial) ? SQR_W'(sq_sh - sq_trial) : SQR_W'(sq_sh);
    assign root_next   = {root_reg[ROOT_W-2:0], (sq_sh >= sq_trial)};

    assign e_val = $signed({3'b000, l_reg}) - $signed({1'b0, root_reg});
    assign e_mag = e_val[ESUB_W-1] ? ROOT_W'(-e_val) : ROOT_W'(e_val);

    // division step
    assign dv_sh       = {div_rem_reg, num_reg[NUM_W-1]};
    assign dv_dvs      = {1'b0, root_reg, {FRAC_W{1'b0}}};
    assign dv_bit      = (dv_sh >= dv_dvs);
    assign dv_rem_next = dv_bit ? DVS_W'(dv_sh - dv_dvs) : DVS_W'(dv_sh);

    assign neg     = e_neg_reg ^ d_reg[j_reg][DIFF_W-1];
    assign big_pos = |num_reg[NUM_W-1:FRC_W-1];
    assign big_neg = (|num_reg[NUM_W-1:FRC_W]) || (num_reg[FRC_W-1] && (|num_reg[FRC_W-2:0]));

    always_comb
    begin
        if (neg)
        begin
            f_sat = big_neg ? FRC_MIN : -$signed(num_reg[FRC_W-1:0]);
        end
        else
        begin
            f_sat = big_pos ? FRC_MAX : $signed(num_reg[FRC_W-1:0]);
        end
    end

    always_comb
    begin
        case (state_reg)
            F_SQ:
            begin
                mul_a = {1'b0, dmag};
                mul_b = {1'b0, dmag};
            end
            F_KE:
            begin
                mul_a = {2'b00, k_reg};
                mul_b = e_mag;
            end
            F_MLO:
            begin
                mul_a = {1'b0, ke_reg[KE_HALF-1:0]};
                mul_b = {1'b0, dmag};
            end
            F_MHI:
            begin
                mul_a = {1'b0, ke_reg[KE_W-1:KE_HALF]};
                mul_b = {1'b0, dmag};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_ch.opcode == OP_READ) ? F_PUSH : F_SQ;
                end
            end
            F_SQ:
            begin
                if (j_reg == 2'd2)
                begin
                    state_next = F_SQRT;
                end
            end
            F_SQRT:
            begin
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    state_next = (root_next == '0) ? F_PUSH : F_KE;
                end
            end
            F_KE:  state_next = F_MLO;
            F_MLO: state_next = F_MHI;
            F_MHI: state_next = F_DIV;
            F_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = F_SAT;
                end
            end
            F_SAT: state_next = (j_reg == 2'd2) ? F_PUSH : F_MLO;
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ch.ready = 1'b0;
        q_push      = 1'b0;
        case (state_reg)
            F_IDLE:  in_ch.ready = !status.clearing;
            F_PUSH:  q_push = !q_full;
            default: ;
        endcase
    end

    assign q_data = '{opcode:        op_reg,
                      first_vertex:  v0_reg,
                      second_vertex: v1_reg,
                      force_x:       f_reg[0],
                      force_y:       f_reg[1],
                      force_z:       f_reg[2],
                      degenerate:    degen_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                F_IDLE:
                begin
                    j_reg   <= '0;
                    cnt_reg <= '0;
                end
                F_SQ:   j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
                F_SQRT: cnt_reg <= (cnt_reg == CNT_W'(ROOT_W - 1)) ? '0 : cnt_reg + 1'b1;
                F_KE:   j_reg <= '0;
                F_MHI:  cnt_reg <= '0;
                F_DIV:  cnt_reg <= (cnt_reg == CNT_W'(NUM_W - 1)) ? '0 : cnt_reg + 1'b1;
                F_SAT:  j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    op_reg     <= in_ch.opcode;
                    v0_reg     <= in_ch.first_vertex;
                    v1_reg     <= in_ch.second_vertex;
                    d_reg[0]   <= DIFF_W'(in_ch.first_x) - DIFF_W'(in_ch.second_x);
                    d_reg[1]   <= DIFF_W'(in_ch.first_y) - DIFF_W'(in_ch.second_y);
                    d_reg[2]   <= DIFF_W'(in_ch.first_z) - DIFF_W'(in_ch.second_z);
                    k_reg      <= in_ch.stiffness;
                    l_reg      <= in_ch.rest_length;
                    acc_reg    <= '0;
                    sq_rem_reg <= '0;
                    root_reg   <= '0;
                    degen_reg  <= 1'b0;
                    f_reg[0]   <= '0;
                    f_reg[1]   <= '0;
                    f_reg[2]   <= '0;
                end
            end
            F_SQ: acc_reg <= acc_reg + SUM_W'(prod);
            F_SQRT:
            begin
                acc_reg    <= {acc_reg[SUM_W-3:0], 2'b00};
                sq_rem_reg <= sq_rem_next;
                root_reg   <= root_next;
                degen_reg  <= (root_next == '0);
            end
            F_KE:
            begin
                ke_reg    <= KE_W'(prod);
                e_neg_reg <= e_val[ESUB_W-1];
            end
            F_MLO: num_reg <= NUM_W'(prod);
            F_MHI:
            begin
                num_reg     <= num_reg + (NUM_W'(prod) << KE_HALF);
                div_rem_reg <= '0;
            end
            F_DIV:
            begin
                div_rem_reg <= dv_rem_next;
                num_reg     <= {num_reg[NUM_W-2:0], dv_bit};
            end
            F_SAT: f_reg[j_reg] <= f_sat;
            default: ;
        endcase
    end
endmodule

// ----- hdl/sfa_queue.sv -----
// ----------------------------------------------------------------------------
// sfa_queue
// two-entry queue between the force front and the accumulate back
// ----------------------------------------------------------------------------
module sfa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfa_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output sfa_pkg::work_t head,
    output logic           empty
);
    import sfa_pkg::*;

    work_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ----- hdl/sfa_back.sv -----
// ----------------------------------------------------------------------------
// sfa_back
// clears the vertex accumulators after reset, applies forces to them,
// serves readouts and holds the result register
// ----------------------------------------------------------------------------
module sfa_back #(
    parameter int NUM_VERTICES = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfa_pkg::work_t        head,
    input  logic                  empty,
    output logic                  pop,
    output sfa_pkg::back_status_t status,
    sfa_out_if.source             out_ch
);
    import sfa_pkg::*;

    localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int IW = ((AW > VTX_W) ? AW : VTX_W) + 1;
    localparam logic [AW-1:0] LAST = AW'(NUM_VERTICES - 1);

    back_state_t state_reg, state_next;
    logic [AW-1:0]           clr_reg;
    work_t                   item_reg;
    logic signed [FRC_W-1:0] res_reg [3];

    logic                    out_valid_reg;
    logic                    out_kind_reg;
    logic [VTX_W-1:0]        out_vertex_reg;
    logic signed [FRC_W-1:0] out_f_reg [3];
    logic                    out_degen_reg;

    logic                    we;
    logic [AW-1:0]           waddr, raddr;
    logic [ACC_W-1:0]        wdata, rdata;
    logic signed [FRC_W-1:0] r_f [3];
    logic                    out_load;

    function automatic logic in_range(input logic [VTX_W-1:0] v);
        return IW'(v) < IW'(NUM_VERTICES);
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [VTX_W-1:0] v);
        logic [IW-1:0] w;
        w = IW'(v);
        return w[AW-1:0];
    endfunction

    assign r_f[0] = rdata[3*FRC_W-1 -: FRC_W];
    assign r_f[1] = rdata[2*FRC_W-1 -: FRC_W];
    assign r_f[2] = rdata[FRC_W-1 -: FRC_W];

    sfa_ram #(
        .WIDTH (ACC_W),
        .DEPTH (NUM_VERTICES)
    ) u_acc_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_load = (state_reg == B_OUT) && (!out_valid_reg || out_ch.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_reg == LAST)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    if (head.opcode == OP_READ)
                    begin
                        state_next = in_range(head.first_vertex) ? B_RD0 : B_OUT;
                    end
                    else if (head.degenerate)
                    begin
                        state_next = B_OUT;
                    end
                    else if (in_range(head.first_vertex))
                    begin
                        state_next = B_RD0;
                    end
                    else
                    begin
                        state_next = in_range(head.second_vertex) ? B_RD1 : B_OUT;
                    end
                end
            end
            B_RD0: state_next = B_WR0;
            B_WR0:
            begin
                if (item_reg.opcode == OP_READ || !in_range(item_reg.second_vertex))
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    state_next = B_RD1;
                end
            end
            B_RD1: state_next = B_WR1;
            B_WR1: state_next = B_OUT;
            B_OUT:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop             = 1'b0;
        we              = 1'b0;
        waddr           = to_addr(item_reg.first_vertex);
        raddr           = to_addr(item_reg.first_vertex);
        wdata           = '0;
        status.clearing = 1'b0;
        status.busy     = 1'b1;
        case (state_reg)
            B_CLEAR:
            begin
                we              = 1'b1;
                waddr           = clr_reg;
                status.clearing = 1'b1;
            end
            B_IDLE:
            begin
                pop         = !empty;
                status.busy = 1'b0;
            end
            B_WR0:
            begin
                we = 1'b1;
                if (item_reg.opcode == OP_SPRING)
                begin
                    wdata = {sat_sum(r_f[0], item_reg.force_x, 1'b0),
                             sat_sum(r_f[1], item_reg.force_y, 1'b0),
                             sat_sum(r_f[2], item_reg.force_z, 1'b0)};
                end
            end
            B_RD1: raddr = to_addr(item_reg.second_vertex);
            B_WR1:
            begin
                we    = 1'b1;
                waddr = to_addr(item_reg.second_vertex);
                wdata = {sat_sum(r_f[0], item_reg.force_x, 1'b1),
                         sat_sum(r_f[1], item_reg.force_y, 1'b1),
                         sat_sum(r_f[2], item_reg.force_z, 1'b1)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg   <= head;
            res_reg[0] <= (head.opcode == OP_READ) ? '0 : head.force_x;
            res_reg[1] <= (head.opcode == OP_READ) ? '0 : head.force_y;
            res_reg[2] <= (head.opcode == OP_READ) ? '0 : head.force_z;
        end
        if (state_reg == B_WR0 && item_reg.opcode == OP_READ)
        begin
            res_reg[0] <= r_f[0];
            res_reg[1] <= r_f[1];
            res_reg[2] <= r_f[2];
        end
        if (out_load)
        begin
            out_kind_reg   <= (item_reg.opcode == OP_READ) ? KIND_READOUT : KIND_FORCE;
            out_vertex_reg <= item_reg.first_vertex;
            out_f_reg[0]   <= res_reg[0];
            out_f_reg[1]   <= res_reg[1];
            out_f_reg[2]   <= res_reg[2];
            out_degen_reg  <= (item_reg.opcode == OP_SPRING) && item_reg.degenerate;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.kind       = out_kind_reg;
    assign out_ch.vertex     = out_vertex_reg;
    assign out_ch.force_x    = out_f_reg[0];
    assign out_ch.force_y    = out_f_reg[1];
    assign out_ch.force_z    = out_f_reg[2];
    assign out_ch.degenerate = out_degen_reg;
endmodule

// ----- hdl/sfa_checker.sv -----
// ----------------------------------------------------------------------------
// sfa_checker
// port level checks of the spring force block
// ----------------------------------------------------------------------------
module sfa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        out_kind,
    input logic                        out_degenerate,
    input logic signed [sfa_pkg::FRC_W-1:0] out_force_x,
    input logic signed [sfa_pkg::FRC_W-1:0] out_force_y,
    input logic signed [sfa_pkg::FRC_W-1:0] out_force_z
);
    import sfa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_degenerate |->
            out_force_x == '0 && out_force_y == '0 && out_force_z == '0)
        else $error("degenerate spring with nonzero force");

    a_readout_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_READOUT |-> !out_degenerate)
        else $error("readout flagged degenerate");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("input taken during accumulator clear");
endmodule

bind spring_force_accumulator sfa_checker u_sfa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_degenerate (out_ch.degenerate),
    .out_force_x    (out_ch.force_x),
    .out_force_y    (out_ch.force_y),
    .out_force_z    (out_ch.force_z)
);

// ----- sim/tb_spring_force_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spring_force_accumulator
// checks spring forces and per-vertex accumulator readouts against an
// independent fixed-point force predictor, under random idling on both sides
// ----------------------------------------------------------------------------
module tb_spring_force_accumulator;
    import sfa_pkg::*;

    typedef struct packed {
        logic                    kind;
        logic [VTX_W-1:0]        vertex;
        logic signed [FRC_W-1:0] force_x;
        logic signed [FRC_W-1:0] force_y;
        logic signed [FRC_W-1:0] force_z;
        logic                    degenerate;
    } force_res_t;

    typedef struct packed {
        logic                    opcode;
        logic [VTX_W-1:0]        v0;
        logic [VTX_W-1:0]        v1;
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        logic signed [POS_W-1:0] az;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
        logic signed [POS_W-1:0] bz;
        logic [POS_W-1:0]        k;
        logic [POS_W-1:0]        rest;
    } spring_item_t;

    typedef struct {
        spring_item_t item;
        logic         has_golden;
        force_res_t   golden;
    } table_row_t;

    localparam int NV = 1024;
    localparam logic signed [POS_W-1:0] PMAX = 32'sh7fffffff;
    localparam logic signed [POS_W-1:0] PMIN = 32'sh80000000;
    localparam logic signed [POS_W-1:0] ONE  = 32'sh00010000;

    logic clk;
    logic rst_n;
    int   errors;
    int   src_idle_pct;
    int   snk_idle_pct;

    logic signed [FRC_W-1:0] acc_x [NV];
    logic signed [FRC_W-1:0] acc_y [NV];
    logic signed [FRC_W-1:0] acc_z [NV];
    force_res_t expected_forces [$];

    sfa_in_if  in_ch ();
    sfa_out_if out_ch ();

    spring_force_accumulator #(.NUM_VERTICES(NV)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [FRC_W-1:0] clamp48(input logic signed [127:0] v);
        if (v > 128'sh7fffffffffff)
        begin
            return FRC_MAX;
        end
        if (v < -128'sh800000000000)
        begin
            return FRC_MIN;
        end
        return v[FRC_W-1:0];
    endfunction

    function automatic force_res_t predict_force(input spring_item_t it);
        force_res_t              r;
        logic signed [127:0]     d [3];
        logic signed [127:0]     e;
        logic signed [127:0]     num;
        logic signed [127:0]     q;
        logic [127:0]            sum;
        logic [127:0]            root;
        logic [127:0]            bitv;
        logic signed [FRC_W-1:0] f [3];
        r.kind = it.opcode;
        r.vertex = it.v0;
        r.degenerate = 1'b0;
        f[0] = '0;
        f[1] = '0;
        f[2] = '0;
        if (it.opcode == OP_READ)
        begin
            f[0] = acc_x[it.v0];
            f[1] = acc_y[it.v0];
            f[2] = acc_z[it.v0];
            acc_x[it.v0] = '0;
            acc_y[it.v0] = '0;
            acc_z[it.v0] = '0;
        end
        else
        begin
            d[0] = 128'(it.ax) - 128'(it.bx);
            d[1] = 128'(it.ay) - 128'(it.by);
            d[2] = 128'(it.az) - 128'(it.bz);
            sum = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
            root = '0;
            for (int b = 34; b >= 0; b--)
            begin
                bitv = root | (128'd1 << b);
                if (bitv * bitv <= sum)
                begin
                    root = bitv;
                end
            end
            if (root == 0)
            begin
                r.degenerate = 1'b1;
            end
            else
            begin
                e = $signed({96'd0, it.rest}) - $signed(root);
                for (int j = 0; j < 3; j++)
                begin
                    num = $signed({96'd0, it.k}) * e * d[j];
                    q = num / $signed(root << 16);
                    f[j] = clamp48(q);
                end
                acc_x[it.v0] = sat_sum(acc_x[it.v0], f[0], 1'b0);
                acc_y[it.v0] = sat_sum(acc_y[it.v0], f[1], 1'b0);
                acc_z[it.v0] = sat_sum(acc_z[it.v0], f[2], 1'b0);
                acc_x[it.v1] = sat_sum(acc_x[it.v1], f[0], 1'b1);
                acc_y[it.v1] = sat_sum(acc_y[it.v1], f[1], 1'b1);
                acc_z[it.v1] = sat_sum(acc_z[it.v1], f[2], 1'b1);
            end
        end
        r.force_x = f[0];
        r.force_y = f[1];
        r.force_z = f[2];
        return r;
    endfunction

    function automatic spring_item_t read_item(input logic [VTX_W-1:0] v);
        spring_item_t it;
        it = spring_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom});
        it.opcode = OP_READ;
        it.v0 = v;
        return it;
    endfunction

    function automatic spring_item_t spring(input logic [VTX_W-1:0] v0, v1,
        input logic signed [POS_W-1:0] ax, ay, az, bx, by, bz,
        input logic [POS_W-1:0] k, rest);
        spring_item_t it;
        it = '{OP_SPRING, v0, v1, ax, ay, az, bx, by, bz, k, rest};
        return it;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
            default: return $urandom_range(0, 1) ? PMAX : PMIN;
        endcase
    endfunction

    function automatic spring_item_t random_item();
        spring_item_t it;
        int           mode;
        mode = $urandom_range(0, 9);
        if ($urandom_range(0, 5) == 0)
        begin
            return read_item(VTX_W'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom));
        end
        it.opcode = OP_SPRING;
        it.v0 = VTX_W'(($urandom_range(0, 2) != 0) ? $urandom_range(0, 15) : $urandom);
        it.v1 = ($urandom_range(0, 3) == 0) ? it.v0 :
                VTX_W'(($urandom_range(0, 2) != 0) ? $urandom_range(0, 15) : $urandom);
        it.ax = rand_pos(mode < 3 ? 0 : (mode < 9 ? 1 : 2));
        it.ay = rand_pos(mode < 3 ? 0 : (mode < 9 ? 1 : 2));
        it.az = rand_pos(mode < 3 ? 0 : (mode < 9 ? 1 : 2));
        if ($urandom_range(0, 15) == 0)
        begin
            it.bx = it.ax;
            it.by = it.ay;
            it.bz = it.az;
        end
        else
        begin
            it.bx = rand_pos(mode < 3 ? 0 : (mode < 9 ? 1 : 2));
            it.by = rand_pos(mode < 3 ? 0 : (mode < 9 ? 1 : 2));
            it.bz = rand_pos(mode < 3 ? 0 : (mode < 9 ? 1 : 2));
        end
        it.k = (mode == 0) ? $urandom : $urandom_range(0, 32'h00100000);
        it.rest = (mode == 0) ? $urandom : $urandom_range(0, 32'h00400000);
        if ($urandom_range(0, 19) == 0)
        begin
            it.k = 32'hffffffff;
        end
        return it;
    endfunction

    task automatic send_item(input spring_item_t it);
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= it.opcode;
        in_ch.first_vertex  <= it.v0;
        in_ch.second_vertex <= it.v1;
        in_ch.first_x       <= it.ax;
        in_ch.first_y       <= it.ay;
        in_ch.first_z       <= it.az;
        in_ch.second_x      <= it.bx;
        in_ch.second_y      <= it.by;
        in_ch.second_z      <= it.bz;
        in_ch.stiffness     <= it.k;
        in_ch.rest_length   <= it.rest;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_and_predict(input spring_item_t it, input logic has_golden,
                                    input force_res_t golden);
        force_res_t r;
        send_item(it);
        r = predict_force(it);
        if (has_golden && r !== golden)
        begin
            $error("directed row golden mismatch: expected %h, predicted %h", golden, r);
            errors++;
        end
        expected_forces.push_back(has_golden ? golden : r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        force_res_t exp_r;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_forces.size() == 0)
            begin
                $error("unexpected transaction on output, vertex %0d", out_ch.vertex);
                errors++;
            end
            else
            begin
                exp_r = expected_forces.pop_front();
                if (out_ch.kind !== exp_r.kind)
                begin
                    $error("kind: expected %0d, actual %0d", exp_r.kind, out_ch.kind);
                    errors++;
                end
                if (out_ch.vertex !== exp_r.vertex)
                begin
                    $error("vertex: expected %0d, actual %0d", exp_r.vertex, out_ch.vertex);
                    errors++;
                end
                if (out_ch.force_x !== exp_r.force_x)
                begin
                    $error("force_x: expected %0d, actual %0d", exp_r.force_x, out_ch.force_x);
                    errors++;
                end
                if (out_ch.force_y !== exp_r.force_y)
                begin
                    $error("force_y: expected %0d, actual %0d", exp_r.force_y, out_ch.force_y);
                    errors++;
                end
                if (out_ch.force_z !== exp_r.force_z)
                begin
                    $error("force_z: expected %0d, actual %0d", exp_r.force_z, out_ch.force_z);
                    errors++;
                end
                if (out_ch.degenerate !== exp_r.degenerate)
                begin
                    $error("degenerate: expected %0d, actual %0d", exp_r.degenerate,
                           out_ch.degenerate);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        table_row_t        rows [$];
        force_res_t        zero_read;
        force_res_t        zero_degen;
        int                wait_cycles;
        errors = 0;
        src_idle_pct = 14;
        snk_idle_pct = 62;
        for (int i = 0; i < NV; i++)
        begin
            acc_x[i] = '0;
            acc_y[i] = '0;
            acc_z[i] = '0;
        end
        rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.opcode <= OP_SPRING;
        in_ch.first_vertex <= '0;
        in_ch.second_vertex <= '0;
        in_ch.first_x <= '0;
        in_ch.first_y <= '0;
        in_ch.first_z <= '0;
        in_ch.second_x <= '0;
        in_ch.second_y <= '0;
        in_ch.second_z <= '0;
        in_ch.stiffness <= '0;
        in_ch.rest_length <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        zero_read = '{KIND_READOUT, 10'd0, '0, '0, '0, 1'b0};
        zero_degen = '{KIND_FORCE, 10'd3, '0, '0, '0, 1'b1};
        // reads after reset, coincident endpoints, extremes
        rows.push_back('{read_item(10'd0), 1'b1, zero_read});
        zero_read.vertex = 10'd1023;
        rows.push_back('{read_item(10'd1023), 1'b1, zero_read});
        rows.push_back('{spring(10'd3, 10'd4, PMAX, PMIN, ONE, PMAX, PMIN, ONE,
                                32'hffffffff, 32'hffffffff), 1'b1, zero_degen});
        zero_read.vertex = 10'd3;
        rows.push_back('{read_item(10'd3), 1'b1, zero_read});
        rows.push_back('{spring(10'd1, 10'd2, ONE, 0, 0, 0, 0, 0, ONE, 2 * ONE), 1'b0, 'x});
        rows.push_back('{spring(10'd1, 10'd2, 0, ONE, 0, 0, 0, 0, ONE, 0), 1'b0, 'x});
        rows.push_back('{spring(10'd5, 10'd5, ONE, ONE, ONE, 0, 0, 0, ONE, 0), 1'b0, 'x});
        rows.push_back('{spring(10'd6, 10'd7, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN,
                                32'hffffffff, 0), 1'b0, 'x});
        rows.push_back('{spring(10'd6, 10'd7, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX,
                                32'hffffffff, 32'hffffffff), 1'b0, 'x});
        rows.push_back('{spring(10'd6, 10'd7, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN,
                                32'hffffffff, 0), 1'b0, 'x});
        rows.push_back('{spring(10'd6, 10'd7, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN,
                                32'hffffffff, 0), 1'b0, 'x});
        rows.push_back('{spring(10'd1023, 10'd0, 0, 0, 1, 0, 0, 0, 32'h0, 32'h10), 1'b0, 'x});
        rows.push_back('{spring(10'd8, 10'd9, 1, 0, 0, 0, 0, 0, 32'hffffffff, 0), 1'b0, 'x});
        rows.push_back('{read_item(10'd1), 1'b0, 'x});
        rows.push_back('{read_item(10'd2), 1'b0, 'x});
        rows.push_back('{read_item(10'd5), 1'b0, 'x});
        rows.push_back('{read_item(10'd6), 1'b0, 'x});
        rows.push_back('{read_item(10'd7), 1'b0, 'x});
        rows.push_back('{read_item(10'd8), 1'b0, 'x});
        rows.push_back('{read_item(10'd1023), 1'b0, 'x});
        foreach (rows[i])
        begin
            send_and_predict(rows[i].item, rows[i].has_golden, rows[i].golden);
        end

        for (int n = 0; n < 950; n++)
        begin
            if (n == 320)
            begin
                src_idle_pct = 62;
                snk_idle_pct = 14;
            end
            else if (n == 640)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            send_and_predict(random_item(), 1'b0, 'x);
        end
        for (int v = 0; v < 16; v++)
        begin
            send_and_predict(read_item(v[VTX_W-1:0]), 1'b0, 'x);
        end
        in_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (expected_forces.size() != 0 && wait_cycles < 2_000_000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_forces.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
